@@ rtl/core/msq_pkg.sv @@
// msq_pkg: shared types and constants of the motor shot sequencer
// no dependencies; imported by every module of the sequencer

package msq_pkg;

  localparam int unsigned PowerW     = 16;
  localparam int unsigned CountW     = 17;
  localparam int unsigned TicksW     = 24;
  localparam int unsigned ShotW      = 16;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned CfgIdxW    = 2;

  localparam int unsigned PreTicksDef   = 50;
  localparam int unsigned PostTicksDef  = 50;
  localparam int unsigned PowerBitsDef  = 16;
  localparam int unsigned TimeoutReset  = 750;

  localparam logic [CfgIdxW-1:0] CFG_SHOT_COUNT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONTINUOUS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COOLING_TICKS = 2'd3;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_SINGLE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SPIN   = 3'd1,
    PH_PEAK   = 3'd2,
    PH_DROP   = 3'd3,
    PH_SETTLE = 3'd4,
    PH_COOL   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ShotW-1:0]    shot_count;
    logic                continuous;
    logic [TimeoutW-1:0] timeout_ticks;
    logic [TicksW-1:0]   cooling_ticks;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic add;
  } avg_ctrl_t;

  typedef struct packed {
    logic above;
    logic below;
  } avg_res_t;

  typedef struct packed {
    logic             motor_on;
    phase_e           phase;
    logic [ShotW-1:0] shots_left;
    logic             shot_finished;
    logic             timed_out;
  } result_t;

endpackage

@@ rtl/core/msq_cfg_regs.sv @@
// msq_cfg_regs: configuration register file of the shot sequencer
// depends on msq_pkg

module msq_cfg_regs import msq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shot_count    <= '0;
      cfg_q.continuous    <= 1'b0;
      cfg_q.timeout_ticks <= TimeoutW'(TimeoutReset);
      cfg_q.cooling_ticks <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHOT_COUNT:    cfg_q.shot_count    <= cfg_wdata_i[ShotW-1:0];
        CFG_CONTINUOUS:    cfg_q.continuous    <= cfg_wdata_i[0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i[TimeoutW-1:0];
        CFG_COOLING_TICKS: cfg_q.cooling_ticks <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/msq_avg.sv @@
// msq_avg: running power average as sum and count, with 1.5x threshold tests
// depends on msq_pkg; one multiplier, compares 2*p*n against 3*sum

module msq_avg import msq_pkg::*; #(
  parameter int unsigned POWER_BITS = PowerBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  avg_ctrl_t         ctrl_i,
  input  logic [PowerW-1:0] power_i,
  output avg_res_t          res_o
);

  localparam int unsigned PW   = (POWER_BITS < PowerW) ? POWER_BITS : PowerW;
  localparam int unsigned SumW = PW + CountW;
  localparam int unsigned CmpW = SumW + 2;
  localparam logic [CountW-1:0] CountMax = '1;

  logic [PW-1:0]     p;
  logic [SumW-1:0]   sum_q, sum_d, sum_new;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_new;
  logic [PW+CountW-1:0] prod;
  logic [CmpW-1:0]   lhs, rhs;

  assign p = power_i[PW-1:0];

  // sum and count freeze once the count saturates
  always_comb begin
    sum_new = sum_q;
    cnt_new = cnt_q;
    if (cnt_q != CountMax) begin
      sum_new = sum_q + SumW'(p);
      cnt_new = cnt_q + 1'b1;
    end
  end

  assign prod = (PW+CountW)'(p) * (PW+CountW)'(cnt_new);
  assign lhs  = {1'b0, prod, 1'b0};
  assign rhs  = CmpW'(sum_new) + {1'b0, sum_new, 1'b0};

  assign res_o.above = lhs > rhs;
  assign res_o.below = lhs < rhs;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sum_new;
      cnt_d = cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/core/msq_seq.sv @@
// msq_seq: shot phase sequencer, tick counter, shot counter and motor drive
// depends on msq_pkg; takes threshold results from msq_avg

module msq_seq import msq_pkg::*; #(
  parameter int unsigned PRE_TICKS  = PreTicksDef,
  parameter int unsigned POST_TICKS = PostTicksDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  mode_e     mode_i,
  input  cfg_t      cfg_i,
  input  avg_res_t  avg_res_i,
  output avg_ctrl_t avg_ctrl_o,
  output result_t   result_o
);

  localparam logic [TicksW-1:0] TicksMax = '1;
  localparam logic [TicksW-1:0] PreLim   = TicksW'(PRE_TICKS);
  localparam logic [TicksW-1:0] PostLim  = TicksW'(POST_TICKS);

  phase_e            phase_q, phase_d;
  logic [TicksW-1:0] ticks_q, ticks_d, ticks_inc;
  logic [ShotW-1:0]  rem_q, rem_d, rem_src;
  logic              drive_q, drive_d;
  logic              single_q, single_d;
  logic              try_shot, cont, fire, hit, finished, tmo;
  avg_ctrl_t         ctrl;

  assign ticks_inc = (ticks_q != TicksMax) ? ticks_q + 1'b1 : ticks_q;
  assign hit = (phase_q == PH_PEAK) ? avg_res_i.above : avg_res_i.below;

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    rem_d    = rem_q;
    drive_d  = drive_q;
    single_d = single_q;
    rem_src  = rem_q;
    try_shot = 1'b0;
    finished = 1'b0;
    tmo      = 1'b0;
    ctrl     = '0;
    case (mode_i)
      MODE_START: begin
        single_d = 1'b0;
        rem_src  = cfg_i.shot_count;
        try_shot = 1'b1;
      end
      MODE_STOP: begin
        single_d = 1'b0;
        drive_d  = 1'b0;
        phase_d  = PH_IDLE;
        ticks_d  = '0;
      end
      MODE_SINGLE: begin
        single_d = 1'b1;
        rem_src  = ShotW'(1);
        try_shot = 1'b1;
      end
      default: begin
        case (phase_q)
          PH_SPIN: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= PreLim) begin
              phase_d = PH_PEAK;
              ticks_d = '0;
            end
          end
          PH_PEAK, PH_DROP: begin
            ticks_d  = ticks_inc;
            ctrl.add = 1'b1;
            if (hit || ticks_inc >= TicksW'(cfg_i.timeout_ticks)) begin
              tmo     = !hit;
              phase_d = (phase_q == PH_PEAK) ? PH_DROP : PH_SETTLE;
              ticks_d = '0;
            end
          end
          PH_SETTLE: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= PostLim) begin
              drive_d = 1'b0;
              phase_d = PH_COOL;
              ticks_d = '0;
            end
          end
          PH_COOL: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= cfg_i.cooling_ticks) begin
              finished = 1'b1;
              try_shot = 1'b1;
            end
          end
          default: ;
        endcase
      end
    endcase

    // shot attempt: fire if unlimited or shots remain, else go idle
    cont = cfg_i.continuous & ~single_d;
    fire = cont | (rem_src != '0);
    if (try_shot) begin
      ticks_d = '0;
      if (fire) begin
        rem_d      = cont ? rem_src : rem_src - 1'b1;
        drive_d    = 1'b1;
        ctrl.clear = 1'b1;
        phase_d    = PH_SPIN;
      end else begin
        rem_d   = rem_src;
        drive_d = 1'b0;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      ticks_q  <= '0;
      rem_q    <= '0;
      drive_q  <= 1'b0;
      single_q <= 1'b0;
    end else if (go_i) begin
      phase_q  <= phase_d;
      ticks_q  <= ticks_d;
      rem_q    <= rem_d;
      drive_q  <= drive_d;
      single_q <= single_d;
    end
  end

  assign avg_ctrl_o.clear = go_i & ctrl.clear;
  assign avg_ctrl_o.add   = go_i & ctrl.add;

  assign result_o.motor_on      = drive_d;
  assign result_o.phase         = phase_d;
  assign result_o.shots_left    = rem_d;
  assign result_o.shot_finished = finished;
  assign result_o.timed_out     = tmo;

  a_drive_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q == (phase_q == PH_SPIN || phase_q == PH_PEAK ||
                phase_q == PH_DROP || phase_q == PH_SETTLE))
    else $error("motor drive out of step with phase");

  a_timeout_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && tmo) |=> (phase_q == PH_DROP || phase_q == PH_SETTLE) && ticks_q == '0)
    else $error("timeout did not advance the wait");

  a_fire_clears_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && try_shot && fire) |=> phase_q == PH_SPIN && drive_q)
    else $error("fired shot did not enter spin-up");

endmodule

@@ rtl/core/motor_shot_sequencer.sv @@
// motor_shot_sequencer: top level, input word register, sequencer, result register
// depends on msq_pkg, msq_cfg_regs, msq_avg, msq_seq
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in       | in_valid_i/in_ready_o  | mode_i, power_i
//   out      | out_valid_o/out_ready_i| motor_on_o, phase_o, shots_left_o,
//            |                        | shot_finished_o, timed_out_o
//   cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// one word per cycle sustained while out_ready_i is high; each word's result is registered
// the state update and threshold test (one multiply, two compares) run between
// the input register and the result register
// a stalled result register holds a full input register, which holds in_ready_o low
// reset clears the phase, counters, running average and both valid flags

module motor_shot_sequencer import msq_pkg::*; #(
  parameter int unsigned PRE_TICKS  = PreTicksDef,
  parameter int unsigned POST_TICKS = PostTicksDef,
  parameter int unsigned POWER_BITS = PowerBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [PowerW-1:0]   power_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                motor_on_o,
  output logic [2:0]          phase_o,
  output logic [ShotW-1:0]    shots_left_o,
  output logic                shot_finished_o,
  output logic                timed_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic              in_valid_q;
  logic [1:0]        mode_q;
  logic [PowerW-1:0] power_q;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              go;
  cfg_t              cfg;
  avg_ctrl_t         avg_ctrl;
  avg_res_t          avg_res;

  assign go         = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q  <= mode_i;
      power_q <= power_i;
    end
    if (go) begin
      res_q <= res_d;
    end
  end

  msq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msq_avg #(
    .POWER_BITS (POWER_BITS)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (avg_ctrl),
    .power_i (power_q),
    .res_o   (avg_res)
  );

  msq_seq #(
    .PRE_TICKS  (PRE_TICKS),
    .POST_TICKS (POST_TICKS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .mode_i     (mode_e'(mode_q)),
    .cfg_i      (cfg),
    .avg_res_i  (avg_res),
    .avg_ctrl_o (avg_ctrl),
    .result_o   (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign motor_on_o      = res_q.motor_on;
  assign phase_o         = 3'(res_q.phase);
  assign shots_left_o    = res_q.shots_left;
  assign shot_finished_o = res_q.shot_finished;
  assign timed_out_o     = res_q.timed_out;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking regression of motor_shot_sequencer, directed table then random shots
// depends on msq_pkg and the motor_shot_sequencer rtl; results checked against table or local model

module testbench;
  import msq_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned WordTarget = 450;

  typedef struct {
    bit                  is_reg;
    logic [1:0]          code;
    logic [CfgDataW-1:0] value;
    bit                  typed;
    result_t             want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          mode_i = MODE_TICK;
  logic [PowerW-1:0]   power_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                motor_on_o;
  logic [2:0]          phase_o;
  logic [ShotW-1:0]    shots_left_o;
  logic                shot_finished_o;
  logic                timed_out_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_SHOT_COUNT;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // local copy of the registers
  logic [ShotW-1:0]    cf_shots = '0;
  logic                cf_cont = 1'b0;
  logic [TimeoutW-1:0] cf_timeout = TimeoutW'(TimeoutReset);
  logic [TicksW-1:0]   cf_cooling = '0;

  // local copy of the sequencer state
  phase_e              st_phase = PH_IDLE;
  logic [ShotW-1:0]    st_left = '0;
  logic [TicksW-1:0]   st_ticks = '0;
  logic [33:0]         st_sum = '0;
  logic [CountW-1:0]   st_count = '0;
  logic                st_drive = 1'b0;
  logic                st_single = 1'b0;

  result_t             pending_results[$];
  result_t             seen, owed;
  int unsigned         faults = 0;
  int unsigned         idle_cycles = 0;
  bit                  steady = 1'b0;

  motor_shot_sequencer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .power_i        (power_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .motor_on_o     (motor_on_o),
    .phase_o        (phase_o),
    .shots_left_o   (shots_left_o),
    .shot_finished_o(shot_finished_o),
    .timed_out_o    (timed_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic result_t res(logic motor, phase_e ph, logic [ShotW-1:0] left);
    result_t r;
    r = '0;
    r.motor_on = motor;
    r.phase = ph;
    r.shots_left = left;
    return r;
  endfunction

  function automatic void enter(phase_e ph);
    st_phase = ph;
    st_ticks = '0;
  endfunction

  function automatic void fire_shot();
    bit free_run;
    free_run = cf_cont && !st_single;
    if (free_run || st_left != 0) begin
      if (!free_run) st_left = st_left - 1'b1;
      st_drive = 1'b1;
      st_sum = '0;
      st_count = '0;
      enter(PH_SPIN);
    end else begin
      st_drive = 1'b0;
      enter(PH_IDLE);
    end
  endfunction

  task automatic advance_sequencer(input mode_e m, input logic [PowerW-1:0] p,
                                   output result_t r);
    longint unsigned lhs, rhs;
    bit hit, fin, tmo;
    fin = 1'b0;
    tmo = 1'b0;
    case (m)
      MODE_START: begin
        st_single = 1'b0;
        st_left = cf_shots;
        fire_shot();
      end
      MODE_STOP: begin
        st_single = 1'b0;
        st_drive = 1'b0;
        enter(PH_IDLE);
      end
      MODE_SINGLE: begin
        st_single = 1'b1;
        st_left = ShotW'(1);
        fire_shot();
      end
      default: begin
        if (st_phase != PH_IDLE && st_ticks != '1) st_ticks = st_ticks + 1'b1;
        case (st_phase)
          PH_SPIN: if (st_ticks >= PreTicksDef) enter(PH_PEAK);
          PH_PEAK, PH_DROP: begin
            if (st_count != '1) begin
              st_sum = st_sum + 34'(p);
              st_count = st_count + 1'b1;
            end
            lhs = 64'(p) * 64'(st_count) * 64'd2;
            rhs = 64'(st_sum) * 64'd3;
            hit = (st_phase == PH_PEAK) ? (lhs > rhs) : (lhs < rhs);
            if (hit || st_ticks >= cf_timeout) begin
              tmo = !hit;
              enter(st_phase == PH_PEAK ? PH_DROP : PH_SETTLE);
            end
          end
          PH_SETTLE: begin
            if (st_ticks >= PostTicksDef) begin
              st_drive = 1'b0;
              enter(PH_COOL);
            end
          end
          PH_COOL: begin
            if (st_ticks >= cf_cooling) begin
              fin = 1'b1;
              fire_shot();
            end
          end
          default: ;
        endcase
      end
    endcase
    r = res(st_drive, st_phase, st_left);
    r.shot_finished = fin;
    r.timed_out = tmo;
  endtask

  // drive one word, wait for it to be taken, queue what it should produce
  task automatic send_word(input mode_e m, input logic [PowerW-1:0] p, input bit typed,
                           input result_t want);
    result_t calc;
    @(negedge clk_i);
    while (!steady && $urandom_range(99, 0) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    power_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_sequencer(m, p, calc);
    pending_results.push_back(typed ? want : calc);
  endtask

  // register write once every queued result has come back
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_SHOT_COUNT:    cf_shots = data[ShotW-1:0];
      CFG_CONTINUOUS:    cf_cont = data[0];
      CFG_TIMEOUT_TICKS: cf_timeout = data[TimeoutW-1:0];
      CFG_COOLING_TICKS: cf_cooling = data[TicksW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) out_ready_i <= steady || ($urandom_range(99, 0) >= 30);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.motor_on = motor_on_o;
      seen.phase = phase_e'(phase_o);
      seen.shots_left = shots_left_o;
      seen.shot_finished = shot_finished_o;
      seen.timed_out = timed_out_o;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        faults++;
      end else begin
        owed = pending_results.pop_front();
        if (seen !== owed) begin
          $display("%0t: expected motor %0d phase %0d left %0d fin %0d tmo %0d", $time,
                   owed.motor_on, owed.phase, owed.shots_left, owed.shot_finished,
                   owed.timed_out);
          $display("%0t: actual   motor %0d phase %0d left %0d fin %0d tmo %0d", $time,
                   seen.motor_on, seen.phase, seen.shots_left, seen.shot_finished,
                   seen.timed_out);
          faults++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("motor_shot_sequencer regression: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t           plan[$];
    result_t             none;
    int unsigned         counted, episode, n, r, base;
    logic [ShotW-1:0]    shots;
    logic                cont;
    logic [TimeoutW-1:0] tmo;
    logic [TicksW-1:0]   cool;
    mode_e               m;
    logic [PowerW-1:0]   p;

    none = '0;
    plan = '{
      '{1'b0, MODE_TICK,   24'h0000,   1'b1, res(0, PH_IDLE, 0)},
      '{1'b0, MODE_TICK,   24'hFFFF,   1'b1, res(0, PH_IDLE, 0)},
      '{1'b0, MODE_START,  24'h0000,   1'b1, res(0, PH_IDLE, 0)},
      '{1'b0, MODE_STOP,   24'h0000,   1'b1, res(0, PH_IDLE, 0)},
      '{1'b0, MODE_SINGLE, 24'h0000,   1'b1, res(1, PH_SPIN, 0)},
      '{1'b0, MODE_TICK,   24'hFFFF,   1'b0, none},
      '{1'b0, MODE_STOP,   24'h0000,   1'b1, res(0, PH_IDLE, 0)},
      '{1'b1, CFG_SHOT_COUNT, 24'hFFFF, 1'b0, none},
      '{1'b0, MODE_START,  24'h0000,   1'b1, res(1, PH_SPIN, 16'hFFFE)},
      '{1'b0, MODE_TICK,   24'h1234,   1'b0, none},
      '{1'b0, MODE_SINGLE, 24'h0000,   1'b1, res(1, PH_SPIN, 0)},
      '{1'b1, CFG_CONTINUOUS, 24'h0001, 1'b0, none},
      '{1'b0, MODE_START,  24'h0000,   1'b1, res(1, PH_SPIN, 16'hFFFF)},
      '{1'b0, MODE_SINGLE, 24'h0000,   1'b1, res(1, PH_SPIN, 0)},
      '{1'b0, MODE_START,  24'h0000,   1'b1, res(1, PH_SPIN, 16'hFFFF)},
      '{1'b0, MODE_TICK,   24'h5555,   1'b0, none},
      '{1'b0, MODE_TICK,   24'hAAAA,   1'b0, none},
      '{1'b0, MODE_STOP,   24'h0000,   1'b1, res(0, PH_IDLE, 16'hFFFF)},
      '{1'b1, CFG_TIMEOUT_TICKS, 24'h0000, 1'b0, none},
      '{1'b1, CFG_COOLING_TICKS, 24'hFFFFFF, 1'b0, none}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].code, plan[i].value);
      else send_word(mode_e'(plan[i].code), plan[i].value[PowerW-1:0], plan[i].typed,
                     plan[i].want);
    end

    counted = 0;
    episode = 0;
    while (counted < WordTarget || episode < 4) begin
      case (episode)
        0: begin shots = 2; cont = 1'b0; tmo = 0; cool = 0; end
        1: begin shots = '1; cont = 1'b0; tmo = '1; cool = 1; end
        2: begin shots = 0; cont = 1'b1; tmo = 1; cool = '1; end
        3: begin shots = 3; cont = 1'b1; tmo = 750; cool = 5; end
        default: begin
          shots = ShotW'(($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0)
                                                     : $urandom_range(4, 0));
          cont = ($urandom_range(2, 0) == 0);
          r = $urandom_range(9, 0);
          tmo = TimeoutW'((r < 7) ? $urandom_range(40, 1) : (r < 8) ? 0
                                                         : $urandom_range(65535, 0));
          cool = TicksW'(($urandom_range(4, 0) != 0) ? $urandom_range(20, 0)
                                                     : $urandom_range(24'hFFFFFF, 0));
        end
      endcase
      write_reg(CFG_SHOT_COUNT, CfgDataW'(shots));
      write_reg(CFG_CONTINUOUS, CfgDataW'(cont));
      write_reg(CFG_TIMEOUT_TICKS, CfgDataW'(tmo));
      write_reg(CFG_COOLING_TICKS, CfgDataW'(cool));
      steady = (episode == 1) || ($urandom_range(9, 0) == 0);

      if (episode < 3) m = MODE_START;
      else if (episode == 3) m = MODE_SINGLE;
      else begin
        r = $urandom_range(99, 0);
        m = (r < 55) ? MODE_START : (r < 85) ? MODE_SINGLE : (r < 93) ? MODE_STOP : MODE_TICK;
      end
      send_word(m, PowerW'($urandom_range(65535, 0)), 1'b0, none);
      counted++;

      // shot profile: steady baseline, sparse spikes, a few arbitrary samples and commands
      base = $urandom_range(3000, 50);
      n = $urandom_range(160, 60);
      repeat (n) begin
        r = $urandom_range(99, 0);
        m = (r < 3) ? mode_e'($urandom_range(3, 1)) : MODE_TICK;
        if (r < 3 || r >= 13) p = PowerW'($urandom_range(base + base / 8, base - base / 8));
        else if (r < 10) p = PowerW'($urandom_range(65535, 3 * base));
        else p = PowerW'($urandom_range(65535, 0));
        send_word(m, p, 1'b0, none);
        counted++;
      end
      episode++;
    end

    steady = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    if (faults == 0) $display("motor_shot_sequencer regression: pass");
    else $display("motor_shot_sequencer regression: fail");
    $finish;
  end

endmodule
